[hw/rtl/mqtt_packet_deframer_assert.svh]
// Assertion macros for the MQTT packet deframer.
`ifndef MQTT_PACKET_DEFRAMER_ASSERT_SVH
`define MQTT_PACKET_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that an expression holds at every rising clock edge out of reset.
`define MPD_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("mqtt_packet_deframer: invariant violated");

// Check that a consequent holds whenever its antecedent holds.
`define MPD_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mqtt_packet_deframer: implication violated");

`else

`define MPD_ASSERT_ALWAYS(label, expr)
`define MPD_ASSERT_IMPLY(label, ante, cons)

`endif

`endif

[hw/rtl/mpd_pkg.sv]
// Types, constants and header check for the MQTT packet deframer.
package mpd_pkg;

  // Field widths
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 28;
  localparam int LEN_COUNT_W = 3;
  localparam int GROUP_W     = 7;
  localparam int SHIFT_W     = 5;
  localparam int NIBBLE_W    = 4;

  // Largest number of remaining-length bytes (1 to 4)
  localparam int MAX_LENGTH_BYTES = 4;

  // Input word kinds
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_ABORT = 1'b1;

  // Flag nibble required by PUBREL, SUBSCRIBE and UNSUBSCRIBE
  localparam logic [NIBBLE_W-1:0] FLAGS_QOS1 = 4'h2;
  localparam logic [NIBBLE_W-1:0] FLAGS_NONE = 4'h0;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_ERR  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_SKIP     = 3'd0,
    ST_HEADER   = 3'd1,
    ST_LENGTH   = 3'd2,
    ST_BODY     = 3'd3,
    ST_COMPLETE = 3'd4,
    ST_ERROR    = 3'd5,
    ST_ABORT    = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    PT_RESERVED0   = 4'd0,
    PT_CONNECT     = 4'd1,
    PT_CONNACK     = 4'd2,
    PT_PUBLISH     = 4'd3,
    PT_PUBACK      = 4'd4,
    PT_PUBREC      = 4'd5,
    PT_PUBREL      = 4'd6,
    PT_PUBCOMP     = 4'd7,
    PT_SUBSCRIBE   = 4'd8,
    PT_SUBACK      = 4'd9,
    PT_UNSUBSCRIBE = 4'd10,
    PT_UNSUBACK    = 4'd11,
    PT_PINGREQ     = 4'd12,
    PT_PINGRESP    = 4'd13,
    PT_DISCONNECT  = 4'd14,
    PT_RESERVED15  = 4'd15
  } pkt_type_t;

  // Accept a header byte only for a known type with the flags it requires
  function automatic logic header_ok(input logic [BYTE_W-1:0] b);
    logic [NIBBLE_W-1:0] t;
    logic [NIBBLE_W-1:0] f;
    logic                ok;
    t = b[BYTE_W-1:NIBBLE_W];
    f = b[NIBBLE_W-1:0];
    case (t)
      PT_PUBREL, PT_SUBSCRIBE, PT_UNSUBSCRIBE: begin
        ok = (f == FLAGS_QOS1);
      end
      PT_PUBLISH: begin
        ok = 1'b1;
      end
      PT_CONNECT, PT_CONNACK, PT_PUBACK, PT_PUBREC, PT_PUBCOMP,
      PT_SUBACK, PT_UNSUBACK, PT_PINGREQ, PT_PINGRESP, PT_DISCONNECT: begin
        ok = (f == FLAGS_NONE);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    return ok;
  endfunction

endpackage

[hw/rtl/mqtt_packet_deframer.sv]
// MQTT packet deframer top level: header check, length decode, body pass-through.
`include "mqtt_packet_deframer_assert.svh"

// Frames MQTT control packets from a byte stream, one word (a stream byte or an
// abort) per cycle, each word answered by exactly one result word in the cycle
// after it is accepted. The frame state (phase, header byte, length
// accumulator and the length and body counters) is updated in the cycle a word
// is taken, and the result lands in an output register; in_ready is high
// whenever that register is empty or is being read in the same cycle, so a
// steady one word per cycle flows through as long as the consumer keeps up.
// Bytes that are not a valid header while waiting are answered as skipped; a
// remaining length that still continues on its fourth byte locks the block in
// an error phase that answers every byte with a length error until an abort.
module mqtt_packet_deframer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [mpd_pkg::BYTE_W-1:0]     data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     status,
  output logic [mpd_pkg::NIBBLE_W-1:0]   packet_type,
  output logic [mpd_pkg::NIBBLE_W-1:0]   header_flags,
  output logic [mpd_pkg::LEN_W-1:0]      remaining_length,
  output logic [mpd_pkg::BYTE_W-1:0]     body_byte,
  output logic [mpd_pkg::LEN_W-1:0]      body_offset
);

  // Frame state
  mpd_pkg::phase_t                  phase;
  logic [mpd_pkg::BYTE_W-1:0]       header_byte;
  logic [mpd_pkg::LEN_W-1:0]        len_acc;
  logic [mpd_pkg::LEN_COUNT_W-1:0]  len_count;
  logic [mpd_pkg::LEN_W-1:0]        body_count;

  mpd_pkg::phase_t                  phase_next;
  logic [mpd_pkg::BYTE_W-1:0]       header_byte_next;
  logic [mpd_pkg::LEN_W-1:0]        len_acc_next;
  logic [mpd_pkg::LEN_COUNT_W-1:0]  len_count_next;
  logic [mpd_pkg::LEN_W-1:0]        body_count_next;

  mpd_pkg::status_t                 status_next;
  logic [mpd_pkg::BYTE_W-1:0]       body_byte_next;
  logic [mpd_pkg::LEN_W-1:0]        body_offset_next;

  logic                             take;
  logic [mpd_pkg::SHIFT_W-1:0]      group_shift;
  logic [mpd_pkg::LEN_W-1:0]        group_val;
  logic [mpd_pkg::LEN_W-1:0]        len_sum;
  logic [mpd_pkg::LEN_COUNT_W-1:0]  len_count_inc;
  logic [mpd_pkg::LEN_W-1:0]        body_count_inc;

  // Take a word whenever the result register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Place the next 7-bit length group, least significant group first
  assign group_shift    = mpd_pkg::SHIFT_W'(len_count[1:0]) *
                          mpd_pkg::SHIFT_W'(mpd_pkg::GROUP_W);
  assign group_val      = mpd_pkg::LEN_W'(data_byte[mpd_pkg::GROUP_W-1:0]) << group_shift;
  assign len_sum        = len_acc + group_val;
  assign len_count_inc  = len_count + 1'b1;
  assign body_count_inc = body_count + 1'b1;

  // Decide the next frame state and the result for the word at the input
  always_comb begin
    phase_next       = phase;
    header_byte_next = header_byte;
    len_acc_next     = len_acc;
    len_count_next   = len_count;
    body_count_next  = body_count;
    status_next      = mpd_pkg::ST_SKIP;
    body_byte_next   = '0;
    body_offset_next = '0;
    if (kind == mpd_pkg::KIND_ABORT) begin
      phase_next       = mpd_pkg::PH_WAIT;
      header_byte_next = '0;
      len_acc_next     = '0;
      len_count_next   = '0;
      body_count_next  = '0;
      status_next      = mpd_pkg::ST_ABORT;
    end else begin
      case (phase)
        mpd_pkg::PH_WAIT: begin
          if (mpd_pkg::header_ok(data_byte)) begin
            header_byte_next = data_byte;
            len_acc_next     = '0;
            len_count_next   = '0;
            body_count_next  = '0;
            phase_next       = mpd_pkg::PH_LEN;
            status_next      = mpd_pkg::ST_HEADER;
          end
        end
        mpd_pkg::PH_LEN: begin
          len_acc_next   = len_sum;
          len_count_next = len_count_inc;
          if (!data_byte[mpd_pkg::BYTE_W-1]) begin
            // Last length byte: an empty packet completes right here
            if (len_sum == '0) begin
              phase_next  = mpd_pkg::PH_WAIT;
              status_next = mpd_pkg::ST_COMPLETE;
            end else begin
              phase_next  = mpd_pkg::PH_BODY;
              status_next = mpd_pkg::ST_LENGTH;
            end
          end else if (len_count_inc >=
                       mpd_pkg::LEN_COUNT_W'(mpd_pkg::MAX_LENGTH_BYTES)) begin
            phase_next  = mpd_pkg::PH_ERR;
            status_next = mpd_pkg::ST_ERROR;
          end else begin
            status_next = mpd_pkg::ST_LENGTH;
          end
        end
        mpd_pkg::PH_BODY: begin
          body_byte_next   = data_byte;
          body_offset_next = body_count;
          body_count_next  = body_count_inc;
          if (body_count_inc == len_acc) begin
            phase_next  = mpd_pkg::PH_WAIT;
            status_next = mpd_pkg::ST_COMPLETE;
          end else begin
            status_next = mpd_pkg::ST_BODY;
          end
        end
        default: begin
          // Error phase: hold until an abort word
          status_next = mpd_pkg::ST_ERROR;
        end
      endcase
    end
  end

  // Advance the frame state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= mpd_pkg::PH_WAIT;
      header_byte <= '0;
      len_acc     <= '0;
      len_count   <= '0;
      body_count  <= '0;
    end else if (take) begin
      phase       <= phase_next;
      header_byte <= header_byte_next;
      len_acc     <= len_acc_next;
      len_count   <= len_count_next;
      body_count  <= body_count_next;
    end
  end

  // Hold the result word until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (take) begin
      status           <= status_next;
      packet_type      <= header_byte_next[mpd_pkg::BYTE_W-1:mpd_pkg::NIBBLE_W];
      header_flags     <= header_byte_next[mpd_pkg::NIBBLE_W-1:0];
      remaining_length <= len_acc_next;
      body_byte        <= body_byte_next;
      body_offset      <= body_offset_next;
    end
  end

  // A packet body is never empty, and its count stays below the length
  `MPD_ASSERT_IMPLY(a_body_len_nonzero, phase == mpd_pkg::PH_BODY, len_acc != '0)
  `MPD_ASSERT_IMPLY(a_body_count_in_range, phase == mpd_pkg::PH_BODY, body_count < len_acc)
  // Length decode never runs past its last byte
  `MPD_ASSERT_IMPLY(a_len_count_in_range, phase == mpd_pkg::PH_LEN, len_count < mpd_pkg::LEN_COUNT_W'(mpd_pkg::MAX_LENGTH_BYTES))
  // A reported body byte lies inside the packet
  `MPD_ASSERT_IMPLY(a_body_offset_in_range, out_valid && status == mpd_pkg::ST_BODY, body_offset < remaining_length)

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the MQTT packet deframer: directed table, then random packets.
module tb_top;
  import mpd_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_WORDS  = 250;
  localparam int SHOW_FAULTS  = 10;

  // One result word as the block should present it
  typedef struct packed {
    status_t               st;
    logic [NIBBLE_W-1:0]   ptype;
    logic [NIBBLE_W-1:0]   flags;
    logic [LEN_W-1:0]      rlen;
    logic [BYTE_W-1:0]     bbyte;
    logic [LEN_W-1:0]      boff;
  } frame_result_t;

  // One row of the directed table; known rows carry a hand-written result
  typedef struct {
    logic          k;
    logic [7:0]    b;
    bit            known;
    frame_result_t res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  kind = KIND_BYTE;
  logic [BYTE_W-1:0]     data_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            status;
  logic [NIBBLE_W-1:0]   packet_type;
  logic [NIBBLE_W-1:0]   header_flags;
  logic [LEN_W-1:0]      remaining_length;
  logic [BYTE_W-1:0]     body_byte;
  logic [LEN_W-1:0]      body_offset;

  // Deframer state as the predictor sees it
  phase_t                fr_phase = PH_WAIT;
  logic [BYTE_W-1:0]     fr_hdr = '0;
  logic [LEN_W-1:0]      fr_len = '0;
  logic [LEN_COUNT_W-1:0] fr_nlen = '0;
  logic [LEN_W-1:0]      fr_nbody = '0;

  frame_result_t         frame_results_due[$];
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  int                    words_counted = 0;
  int                    results_checked = 0;
  int                    fault_count = 0;
  int                    cycle_count = 0;
  int                    status_seen[8];
  dir_row_t              dir_rows[26];

  mqtt_packet_deframer dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .data_byte        (data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .packet_type      (packet_type),
    .header_flags     (header_flags),
    .remaining_length (remaining_length),
    .body_byte        (body_byte),
    .body_offset      (body_offset)
  );

  always #6 clk = ~clk;

  // Accept a header only for a known type carrying the flags it demands
  function automatic bit header_accepted(input logic [BYTE_W-1:0] b);
    pkt_type_t t;
    t = pkt_type_t'(b[7:4]);
    case (t)
      PT_RESERVED0, PT_RESERVED15: return 1'b0;
      PT_PUBLISH: return 1'b1;
      PT_PUBREL, PT_SUBSCRIBE, PT_UNSUBSCRIBE: return b[3:0] == FLAGS_QOS1;
      default: return b[3:0] == FLAGS_NONE;
    endcase
  endfunction

  // Advance the deframer state by one word and return the result it gives
  function automatic frame_result_t advance_deframe(input logic k, input logic [BYTE_W-1:0] b);
    frame_result_t r;
    logic [SHIFT_W-1:0] sh;
    r = '0;
    if (k == KIND_ABORT) begin
      fr_phase = PH_WAIT;
      fr_hdr   = '0;
      fr_len   = '0;
      fr_nlen  = '0;
      fr_nbody = '0;
      r.st     = ST_ABORT;
    end else begin
      case (fr_phase)
        PH_WAIT: begin
          if (header_accepted(b)) begin
            fr_hdr   = b;
            fr_len   = '0;
            fr_nlen  = '0;
            fr_nbody = '0;
            fr_phase = PH_LEN;
            r.st     = ST_HEADER;
          end else begin
            r.st = ST_SKIP;
          end
        end
        PH_LEN: begin
          // Least significant group first, seven bits per length byte
          sh = SHIFT_W'(GROUP_W * fr_nlen[1:0]);
          fr_len = fr_len + (LEN_W'(b[6:0]) << sh);
          fr_nlen = fr_nlen + 1'b1;
          if (!b[7]) begin
            if (fr_len == '0) begin
              fr_phase = PH_WAIT;
              r.st     = ST_COMPLETE;
            end else begin
              fr_phase = PH_BODY;
              r.st     = ST_LENGTH;
            end
          end else if (fr_nlen >= MAX_LENGTH_BYTES) begin
            fr_phase = PH_ERR;
            r.st     = ST_ERROR;
          end else begin
            r.st = ST_LENGTH;
          end
        end
        PH_BODY: begin
          r.bbyte  = b;
          r.boff   = fr_nbody;
          fr_nbody = fr_nbody + 1'b1;
          if (fr_nbody == fr_len) begin
            fr_phase = PH_WAIT;
            r.st     = ST_COMPLETE;
          end else begin
            r.st = ST_BODY;
          end
        end
        default: begin
          r.st = ST_ERROR;
        end
      endcase
    end
    r.ptype = fr_hdr[7:4];
    r.flags = fr_hdr[3:0];
    r.rlen  = fr_len;
    return r;
  endfunction

  function automatic dir_row_t pred_row(input logic k, input logic [7:0] b);
    dir_row_t d;
    d.k     = k;
    d.b     = b;
    d.known = 1'b0;
    d.res   = '0;
    return d;
  endfunction

  function automatic dir_row_t known_row(input logic k, input logic [7:0] b, input status_t st,
                                         input logic [3:0] pt, input logic [3:0] fl,
                                         input logic [LEN_W-1:0] rl);
    dir_row_t d;
    d.k         = k;
    d.b         = b;
    d.known     = 1'b1;
    d.res       = '0;
    d.res.st    = st;
    d.res.ptype = pt;
    d.res.flags = fl;
    d.res.rlen  = rl;
    return d;
  endfunction

  // Offer one word, hold it until taken, then queue its result
  task automatic send_word(input logic k, input logic [7:0] b, input bit use_known,
                           input frame_result_t known);
    frame_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = advance_deframe(k, b);
    frame_results_due.push_back(use_known ? known : pred);
    if (pred.st != ST_SKIP) words_counted++;
    @(negedge clk);
  endtask

  // Hold the sender off until every queued result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (frame_results_due.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed packets with random content, plus noise and broken ones
  task automatic send_random_packet();
    logic [7:0]       hdr;
    logic [LEN_W-1:0] len;
    pkt_type_t        t;
    int               r;
    int               nbytes;
    int               nbody;
    // resync with an abort when the last packet was left open
    if (fr_phase != PH_WAIT) send_word(KIND_ABORT, 8'($urandom), 1'b0, '0);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_word(KIND_BYTE, 8'($urandom), 1'b0, '0);
      return;
    end
    if (r < 11) begin
      send_word(KIND_ABORT, 8'($urandom), 1'b0, '0);
      return;
    end
    t = pkt_type_t'($urandom_range(PT_CONNECT, PT_DISCONNECT));
    case (t)
      PT_PUBLISH: hdr = {t, 4'($urandom)};
      PT_PUBREL, PT_SUBSCRIBE, PT_UNSUBSCRIBE: hdr = {t, FLAGS_QOS1};
      default: hdr = {t, FLAGS_NONE};
    endcase
    send_word(KIND_BYTE, hdr, 1'b0, '0);
    if (r < 15) begin
      // length that never stops continuing, some ignored bytes, then abort
      repeat (MAX_LENGTH_BYTES) send_word(KIND_BYTE, 8'h80 | 8'($urandom_range(0, 127)), 1'b0, '0);
      repeat ($urandom_range(0, 3)) send_word(KIND_BYTE, 8'($urandom), 1'b0, '0);
      send_word(KIND_ABORT, 8'($urandom), 1'b0, '0);
      return;
    end
    if (r < 19) begin
      // huge declared length, cut short
      len    = LEN_W'($urandom_range(2 ** 21, 2 ** 28 - 1));
      nbytes = MAX_LENGTH_BYTES;
      nbody  = $urandom_range(0, 5);
    end else begin
      case ($urandom_range(0, 9))
        0: len = LEN_W'($urandom_range(128, 300));
        1: len = LEN_W'($urandom_range(11, 127));
        default: len = LEN_W'($urandom_range(0, 10));
      endcase
      nbytes = 1;
      while (nbytes < MAX_LENGTH_BYTES && (len >> (GROUP_W * nbytes)) != 0) nbytes++;
      // pad the length with extra zero groups now and then
      if ($urandom_range(0, 4) == 0) nbytes = $urandom_range(nbytes, MAX_LENGTH_BYTES);
      nbody = len;
      if (len != 0 && $urandom_range(0, 19) == 0) nbody = $urandom_range(0, len - 1);
    end
    for (int i = 0; i < nbytes; i++) begin
      send_word(KIND_BYTE, {(i < nbytes - 1), 7'(len >> (GROUP_W * i))}, 1'b0, '0);
    end
    for (int i = 0; i < nbody; i++) begin
      send_word(KIND_BYTE, 8'($urandom), 1'b0, '0);
    end
  endtask

  // Stall the result side at the current rate
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (frame_results_due.size() == 0) begin
        fault_count++;
        if (fault_count <= SHOW_FAULTS)
          $display("unexpected result: st=%0d pt=%h fl=%h len=%0d byte=%h off=%0d",
                   status, packet_type, header_flags, remaining_length, body_byte, body_offset);
      end else begin
        want = frame_results_due.pop_front();
        results_checked++;
        status_seen[want.st]++;
        if (status !== want.st || packet_type !== want.ptype || header_flags !== want.flags ||
            remaining_length !== want.rlen || body_byte !== want.bbyte ||
            body_offset !== want.boff) begin
          fault_count++;
          if (fault_count <= SHOW_FAULTS) begin
            $display("mismatch: want st=%0d pt=%h fl=%h len=%0d byte=%h off=%0d",
                     want.st, want.ptype, want.flags, want.rlen, want.bbyte, want.boff);
            $display("          got  st=%0d pt=%h fl=%h len=%0d byte=%h off=%0d",
                     status, packet_type, header_flags, remaining_length, body_byte, body_offset);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int idle_send[4];
    int idle_recv[4];
    int phase_start;
    idle_send = '{0, 85, 0, 32};
    idle_recv = '{0, 0, 85, 32};
    dir_rows = '{
      known_row(KIND_BYTE, 8'h00, ST_SKIP, 4'h0, 4'h0, '0),        // reserved type 0
      known_row(KIND_BYTE, 8'hFF, ST_SKIP, 4'h0, 4'h0, '0),        // reserved type 15
      known_row(KIND_BYTE, 8'h60, ST_SKIP, 4'h0, 4'h0, '0),        // PUBREL, wrong flags
      pred_row(KIND_BYTE, 8'h62),
      known_row(KIND_BYTE, 8'h00, ST_COMPLETE, PT_PUBREL, FLAGS_QOS1, '0),  // zero length
      pred_row(KIND_BYTE, 8'h3F),                                  // PUBLISH, any flags
      pred_row(KIND_BYTE, 8'h02),
      pred_row(KIND_BYTE, 8'hFF),
      pred_row(KIND_BYTE, 8'h00),
      pred_row(KIND_BYTE, 8'hC0),                                  // PINGREQ
      pred_row(KIND_BYTE, 8'hFF),
      pred_row(KIND_BYTE, 8'hFF),
      pred_row(KIND_BYTE, 8'hFF),
      known_row(KIND_BYTE, 8'hFF, ST_ERROR, PT_PINGREQ, FLAGS_NONE, 28'h0FFFFFFF),
      known_row(KIND_BYTE, 8'h55, ST_ERROR, PT_PINGREQ, FLAGS_NONE, 28'h0FFFFFFF),
      known_row(KIND_ABORT, 8'hFF, ST_ABORT, 4'h0, 4'h0, '0),
      pred_row(KIND_BYTE, 8'h82),                                  // SUBSCRIBE
      pred_row(KIND_BYTE, 8'h80),
      pred_row(KIND_BYTE, 8'h80),
      pred_row(KIND_BYTE, 8'h80),
      known_row(KIND_BYTE, 8'h00, ST_COMPLETE, PT_SUBSCRIBE, FLAGS_QOS1, '0),
      pred_row(KIND_BYTE, 8'hE0),                                  // DISCONNECT, one body byte
      pred_row(KIND_BYTE, 8'h01),
      pred_row(KIND_BYTE, 8'hAB),
      pred_row(KIND_BYTE, 8'h10),                                  // CONNECT, aborted in length
      known_row(KIND_ABORT, 8'h00, ST_ABORT, 4'h0, 4'h0, '0)
    };

    // Hold reset, then release on a falling edge
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_word(dir_rows[i].k, dir_rows[i].b, dir_rows[i].known,
                                    dir_rows[i].res);
    wait_results_drained();

    // Random packets under each idle and stall pattern
    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = idle_send[m];
      recv_stall_pct = idle_recv[m];
      phase_start    = words_counted;
      while (words_counted - phase_start < PHASE_WORDS) send_random_packet();
      wait_results_drained();
    end

    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    fault_count += frame_results_due.size();

    $display("Covered %0d words: %0d headers, %0d packets done, %0d length errors, %0d aborts,",
             words_counted, status_seen[ST_HEADER], status_seen[ST_COMPLETE],
             status_seen[ST_ERROR], status_seen[ST_ABORT]);
    $display("  %0d skipped bytes; %0d results checked, %0d faults.",
             status_seen[ST_SKIP], results_checked, fault_count);
    if (fault_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
